### sv/nsvd_pkg.sv
// nsvd_pkg: types and constants shared by the nibble-split varint decoder
// no dependencies

package nsvd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned CNT_W   = 4;

    localparam logic [BYTE_W-1:0] HDR_LONG_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] SHORT_MASK   = 8'h7f;
    localparam logic [2:0]        COUNT_MASK   = 3'h7;
    localparam logic [BYTE_W-1:0] LOW_NIBBLE   = 8'h0f;
    localparam logic [BYTE_W-1:0] HIGH_NIBBLE  = 8'hf0;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } nsvd_result_t;

    typedef struct packed {
        logic             in_progress;
        logic [CNT_W-1:0] bytes_left;
    } nsvd_status_t;

endpackage

### sv/nsvd_step.sv
// nsvd_step: decode state registers and the per-byte update
// depends on nsvd_pkg

module nsvd_step (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic [nsvd_pkg::BYTE_W-1:0]  byte_in,
    output nsvd_pkg::nsvd_result_t       result,
    output nsvd_pkg::nsvd_status_t       status
);

    logic                          in_progress_reg, in_progress_next;
    logic [nsvd_pkg::CNT_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [nsvd_pkg::NIB_W-1:0]    held_nib_reg, held_nib_next;
    logic [nsvd_pkg::VALUE_W-1:0]  acc_reg, acc_next;
    logic [nsvd_pkg::BYTE_W-1:0]   payload;
    logic [nsvd_pkg::BYTE_W-1:0]   short_val;
    logic [nsvd_pkg::BYTE_W-1:0]   high_part;
    logic [2:0]                    count_m1;

    assign high_part = byte_in & nsvd_pkg::HIGH_NIBBLE;
    assign payload   = {high_part[7:4], held_nib_reg};
    assign short_val = byte_in & nsvd_pkg::SHORT_MASK;
    assign count_m1  = byte_in[6:4] & nsvd_pkg::COUNT_MASK;

    always_comb begin
        in_progress_next = in_progress_reg;
        bytes_left_next  = bytes_left_reg;
        held_nib_next    = held_nib_reg;
        acc_next         = acc_reg;
        result.valid     = 1'b0;
        result.value     = acc_reg;
        if (take) begin
            if (!in_progress_reg) begin
                if ((byte_in & nsvd_pkg::HDR_LONG_BIT) == '0) begin
                    result.valid = 1'b1;
                    result.value = {{(nsvd_pkg::VALUE_W-nsvd_pkg::BYTE_W){1'b0}}, short_val};
                end else begin
                    acc_next         = '0;
                    bytes_left_next  = {1'b0, count_m1} + 4'd1;
                    held_nib_next    = byte_in[3:0];
                    in_progress_next = 1'b1;
                end
            end else begin
                acc_next        = {acc_reg[nsvd_pkg::VALUE_W-nsvd_pkg::BYTE_W-1:0], payload};
                held_nib_next   = byte_in[3:0];
                bytes_left_next = bytes_left_reg - 4'd1;
                if (bytes_left_next == '0) begin
                    in_progress_next = 1'b0;
                    result.valid     = 1'b1;
                    result.value     = acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_progress_reg <= 1'b0;
            bytes_left_reg  <= '0;
            held_nib_reg    <= '0;
            acc_reg         <= '0;
        end else begin
            in_progress_reg <= in_progress_next;
            bytes_left_reg  <= bytes_left_next;
            held_nib_reg    <= held_nib_next;
            acc_reg         <= acc_next;
        end
    end

    assign status.in_progress = in_progress_reg;
    assign status.bytes_left  = bytes_left_reg;

endmodule

### sv/nibble_split_varint_decoder.sv
// nibble_split_varint_decoder: top level, stream ports and result register
// depends on nsvd_pkg and nsvd_step
//
// usage
// the slave channel takes the encoded stream one byte per request. a byte
// with bit 7 clear, seen while a header is expected, is a complete value of
// its low 7 bits. otherwise bits 6..4 give the payload length minus one
// (1 to 8 bytes); each payload byte joins the held low nibble of one stream
// byte with the high nibble of the next, first byte most significant.
// the master channel carries one 64-bit value per completed encoding; bytes
// that complete nothing give no request there.
// the value appears on m_tvalid in the cycle after the byte that completes
// it is accepted. throughput: one byte per cycle unless the receiver stalls,
// set by the single decode step between decoder state and result register.
// a stalled receiver holds the result register; s_tready then stays low
// until that result is taken, so no byte is lost.
// reset clears the decoder to expect a header and empties the result register.

module nibble_split_varint_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] value
);

    logic                          take;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [nsvd_pkg::VALUE_W-1:0]  m_tdata_reg, m_tdata_next;
    nsvd_pkg::nsvd_result_t        result;
    nsvd_pkg::nsvd_status_t        status;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    nsvd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .byte_in (s_tdata),
        .result  (result),
        .status  (status)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_tready) begin
            m_tvalid_next = result.valid;
            m_tdata_next  = result.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // busy exactly while payload bytes remain
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.in_progress == (status.bytes_left != '0))
        else $error("in_progress disagrees with bytes_left");

    // short header yields its low 7 bits on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && !status.in_progress && !s_tdata[7]
        |=> m_tvalid && m_tdata == {57'b0, $past(s_tdata[6:0])})
        else $error("short header not delivered");

    // long header produces no request
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && !status.in_progress && s_tdata[7]
        |=> !m_tvalid && status.in_progress)
        else $error("long header handled wrongly");

endmodule

### tb/nsvd_value_checker.sv
// nsvd_value_checker: watches both stream channels of the nibble-split varint decoder,
// predicts each decoded value from the accepted bytes and compares it with the results
// depends on nsvd_pkg
`timescale 1ns / 100ps

module nsvd_value_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [nsvd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] byte_in
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [nsvd_pkg::VALUE_W-1:0] m_tdata,   // [63:0] value
    output int unsigned                  error_count,
    output int unsigned                  values_pending
);

    logic                         hdr_open;
    logic [nsvd_pkg::CNT_W-1:0]   payload_left;
    logic [nsvd_pkg::NIB_W-1:0]   carry_nib;
    logic [nsvd_pkg::VALUE_W-1:0] value_acc;
    logic [nsvd_pkg::VALUE_W-1:0] expected_values[$];

    initial begin
        error_count    = 0;
        values_pending = 0;
    end

    task automatic decode_byte(input logic [nsvd_pkg::BYTE_W-1:0] b);
        logic [nsvd_pkg::BYTE_W-1:0] payload;
        if (!hdr_open) begin
            if ((b & nsvd_pkg::HDR_LONG_BIT) == '0) begin
                expected_values.push_back((nsvd_pkg::VALUE_W)'(b & nsvd_pkg::SHORT_MASK));
            end else begin
                value_acc    = '0;
                payload_left = (nsvd_pkg::CNT_W)'((b >> 4)
                               & (nsvd_pkg::BYTE_W)'(nsvd_pkg::COUNT_MASK))
                               + (nsvd_pkg::CNT_W)'(1);
                carry_nib    = (nsvd_pkg::NIB_W)'(b & nsvd_pkg::LOW_NIBBLE);
                hdr_open     = 1'b1;
            end
        end else begin
            payload      = (nsvd_pkg::BYTE_W)'(carry_nib) | (b & nsvd_pkg::HIGH_NIBBLE);
            value_acc    = {value_acc[nsvd_pkg::VALUE_W-nsvd_pkg::BYTE_W-1:0], payload};
            carry_nib    = (nsvd_pkg::NIB_W)'(b & nsvd_pkg::LOW_NIBBLE);
            payload_left = payload_left - (nsvd_pkg::CNT_W)'(1);
            if (payload_left == '0) begin
                hdr_open = 1'b0;
                expected_values.push_back(value_acc);
            end
        end
    endtask

    task automatic note_error(input string what, input logic [nsvd_pkg::VALUE_W-1:0] want,
                              input logic [nsvd_pkg::VALUE_W-1:0] got);
        if (error_count < 10) begin
            $display("%0t: %s value: expected %h, got %h", $realtime, what, want, got);
        end
        error_count = error_count + 1;
    endtask

    always @(posedge aclk) begin : watch_channels
        logic [nsvd_pkg::VALUE_W-1:0] want;
        if (!aresetn) begin
            hdr_open     = 1'b0;
            payload_left = '0;
            carry_nib    = '0;
            value_acc    = '0;
            expected_values.delete();
        end else begin
            // the result at this edge belongs to an earlier byte
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    note_error("unexpected", 'x, m_tdata);
                end else begin
                    want = expected_values.pop_front();
                    if (m_tdata !== want) begin
                        note_error("wrong", want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
        end
        values_pending = expected_values.size();
    end

endmodule

### tb/nibble_split_varint_decoder_tb.sv
// nibble_split_varint_decoder_tb: byte stream stimulus and verdict for the decoder
// depends on nsvd_pkg, nibble_split_varint_decoder and nsvd_value_checker
`timescale 1ns / 100ps

module nibble_split_varint_decoder_tb;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [nsvd_pkg::BYTE_W-1:0]  s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [nsvd_pkg::VALUE_W-1:0] m_tdata;

    int unsigned check_errors;
    int unsigned values_pending;
    int unsigned bytes_sent = 0;
    bit          no_gaps    = 1'b0;

    nibble_split_varint_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nsvd_value_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .error_count    (check_errors),
        .values_pending (values_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 24);
        end
    end

    task automatic send_byte(input logic [nsvd_pkg::BYTE_W-1:0] b);
        no_gaps = (bytes_sent >= 500 && bytes_sent < 800);
        while (!no_gaps && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent = bytes_sent + 1;
    endtask

    // long form with random payload nibbles
    task automatic send_long(input int unsigned n);
        send_byte({1'b1, 3'(n - 1), 4'($urandom_range(0, 15))});
        repeat (n) send_byte(8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned pick;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short forms at the extremes and in between
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h55);
        // one payload byte, all ones
        send_byte(8'h8f);
        send_byte(8'hff);
        // eight payload bytes, continuations with bit 7 set and clear
        send_byte(8'hfa);
        send_byte(8'h80);
        send_byte(8'hff);
        send_byte(8'h01);
        send_byte(8'hfe);
        send_byte(8'h7f);
        send_byte(8'h00);
        send_byte(8'h9c);
        send_byte(8'h3b);
        // two payload bytes
        send_byte(8'h95);
        send_byte(8'h00);
        send_byte(8'h7f);
        // three payload bytes
        send_byte(8'ha3);
        send_byte(8'hc4);
        send_byte(8'h2a);
        send_byte(8'hf0);

        while (bytes_sent < 1300) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_byte(8'($urandom_range(0, 127)));
            end else if (pick < 40) begin
                send_byte(8'($urandom));
            end else begin
                send_long($urandom_range(1, 8));
            end
        end
        // finish any encoding left open by raw bytes
        send_long(8);
        s_tvalid <= 1'b0;

        while (values_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (check_errors == 0 && values_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### nibble_split_varint_decoder.f
sv/nsvd_pkg.sv
sv/nsvd_step.sv
sv/nibble_split_varint_decoder.sv
tb/nsvd_value_checker.sv
tb/nibble_split_varint_decoder_tb.sv
